// ===== rtl/core/evad_pkg.sv =====
package evad_pkg;

    localparam int MAX_FRAME_LENGTH = 4096;
    localparam int RUN_COUNT_WIDTH  = 10;

    localparam int SAMPLE_W       = 16;
    localparam int SQUARE_W       = 2 * SAMPLE_W;
    localparam int ENERGY_W       = 43;
    localparam int FRAME_LEN_W    = 13;
    localparam int MIN_RUN_W      = 10;
    localparam int HOLD_SAMPLES_W = 20;
    localparam int HOLD_W         = 22;
    localparam int POS_W          = $clog2(MAX_FRAME_LENGTH);
    localparam int EFF_LEN_W      = POS_W + 1;
    localparam int RUN_CMP_W      = (RUN_COUNT_WIDTH > MIN_RUN_W) ? RUN_COUNT_WIDTH : MIN_RUN_W;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = ENERGY_W;

    localparam logic [ENERGY_W-1:0]        ENERGY_MAX = '1;
    localparam logic [RUN_COUNT_WIDTH-1:0] RUN_MAX    = '1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_LENGTH      = 3'd0,
        CFG_ENERGY_THRESHOLD  = 3'd1,
        CFG_MIN_LOUD_FRAMES   = 3'd2,
        CFG_MIN_QUIET_FRAMES  = 3'd3,
        CFG_HOLD_SAMPLES      = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic                frame_end;
        logic [ENERGY_W-1:0] energy;
    } frame_info_t;

    typedef struct packed {
        logic                frame_end;
        logic [ENERGY_W-1:0] frame_energy;
        logic                loud_frame;
        logic                speaking_now;
        logic                speech_started;
        logic                speech_ended;
        logic                frame_captured;
    } result_t;

    // Frame length as used: zero counts as one, and it is capped at the maximum.
    function automatic logic [EFF_LEN_W-1:0] eff_length(input logic [FRAME_LEN_W-1:0] len);
        logic [EFF_LEN_W-1:0] n;
        if (len == '0) begin
            n = EFF_LEN_W'(1);
        end else if (32'(len) > 32'(MAX_FRAME_LENGTH)) begin
            n = EFF_LEN_W'(MAX_FRAME_LENGTH);
        end else begin
            n = EFF_LEN_W'(len);
        end
        return n;
    endfunction

endpackage

// ===== rtl/core/evad_input_stage.sv =====
module evad_input_stage (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [evad_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                                 advance,
    output logic                                 sq_valid,
    output logic        [evad_pkg::SQUARE_W-1:0] square
);

    logic                            valid_reg;
    logic                            valid_next;
    logic [evad_pkg::SQUARE_W-1:0]   square_reg;
    logic signed [evad_pkg::SQUARE_W-1:0] product;

    assign product = s_sample * s_sample;
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // The square of a 16-bit value is never negative, so the product is taken as unsigned.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            square_reg <= $unsigned(product);
        end
    end

    assign sq_valid = valid_reg;
    assign square   = square_reg;

endmodule

// ===== rtl/core/evad_frame_acc.sv =====
module evad_frame_acc (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   advance,
    input  logic [evad_pkg::SQUARE_W-1:0]          square,
    input  logic [evad_pkg::EFF_LEN_W-1:0]         frame_len,
    output evad_pkg::frame_info_t                  frame_info
);

    logic [evad_pkg::POS_W-1:0]     pos_reg;
    logic [evad_pkg::POS_W-1:0]     pos_next;
    logic [evad_pkg::ENERGY_W-1:0]  sum_reg;
    logic [evad_pkg::ENERGY_W-1:0]  sum_next;
    logic [evad_pkg::EFF_LEN_W-1:0] pos_plus;
    logic [evad_pkg::ENERGY_W:0]    sum_wide;
    logic [evad_pkg::ENERGY_W-1:0]  sum_sat;
    logic                           last_sample;

    assign pos_plus    = {1'b0, pos_reg} + evad_pkg::EFF_LEN_W'(1);
    // A frame also ends at once if the length was lowered below the current position.
    assign last_sample = !(pos_plus < frame_len);

    assign sum_wide = {1'b0, sum_reg} + (evad_pkg::ENERGY_W + 1)'(square);
    assign sum_sat  = sum_wide[evad_pkg::ENERGY_W] ? evad_pkg::ENERGY_MAX
                                                   : sum_wide[evad_pkg::ENERGY_W-1:0];

    always_comb begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        if (advance) begin
            if (last_sample) begin
                pos_next = '0;
                sum_next = '0;
            end else begin
                pos_next = pos_plus[evad_pkg::POS_W-1:0];
                sum_next = sum_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            sum_reg <= '0;
        end else begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

    assign frame_info.frame_end = last_sample;
    assign frame_info.energy    = sum_sat;

endmodule

// ===== rtl/core/evad_speech_ctrl.sv =====
module evad_speech_ctrl (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  advance,
    input  evad_pkg::frame_info_t                 frame_info,
    input  logic [evad_pkg::EFF_LEN_W-1:0]        frame_len,
    input  logic [evad_pkg::ENERGY_W-1:0]         threshold,
    input  logic [evad_pkg::MIN_RUN_W-1:0]        min_loud,
    input  logic [evad_pkg::MIN_RUN_W-1:0]        min_quiet,
    input  logic [evad_pkg::HOLD_SAMPLES_W-1:0]   hold_samples,
    output evad_pkg::result_t                     result
);

    logic                                   in_speech_reg;
    logic                                   in_speech_next;
    logic [evad_pkg::RUN_COUNT_WIDTH-1:0]   loud_run_reg;
    logic [evad_pkg::RUN_COUNT_WIDTH-1:0]   loud_run_next;
    logic [evad_pkg::RUN_COUNT_WIDTH-1:0]   quiet_run_reg;
    logic [evad_pkg::RUN_COUNT_WIDTH-1:0]   quiet_run_next;
    logic signed [evad_pkg::HOLD_W-1:0]     hold_reg;
    logic signed [evad_pkg::HOLD_W-1:0]     hold_next;
    logic signed [evad_pkg::HOLD_W-1:0]     hold_after;
    logic signed [evad_pkg::HOLD_W-1:0]     len_s;
    logic signed [evad_pkg::HOLD_W-1:0]     reload_s;
    logic [evad_pkg::MIN_RUN_W-1:0]         need_loud;
    logic [evad_pkg::MIN_RUN_W-1:0]         need_quiet;
    logic [evad_pkg::RUN_COUNT_WIDTH-1:0]   loud_inc;
    logic [evad_pkg::RUN_COUNT_WIDTH-1:0]   quiet_inc;
    logic                                   loud;
    logic                                   started;
    logic                                   ended;
    logic                                   captured;

    assign need_loud  = (min_loud  == '0) ? evad_pkg::MIN_RUN_W'(1) : min_loud;
    assign need_quiet = (min_quiet == '0) ? evad_pkg::MIN_RUN_W'(1) : min_quiet;
    assign loud_inc   = (loud_run_reg  == evad_pkg::RUN_MAX) ? loud_run_reg  : loud_run_reg  + 1'b1;
    assign quiet_inc  = (quiet_run_reg == evad_pkg::RUN_MAX) ? quiet_run_reg : quiet_run_reg + 1'b1;
    assign len_s      = $signed(evad_pkg::HOLD_W'(frame_len));
    assign reload_s   = $signed(evad_pkg::HOLD_W'(hold_samples)) + len_s;
    assign loud       = frame_info.energy >= threshold;

    always_comb begin
        in_speech_next = in_speech_reg;
        loud_run_next  = loud_run_reg;
        quiet_run_next = quiet_run_reg;
        hold_next      = hold_reg;
        hold_after     = hold_reg;
        started        = 1'b0;
        ended          = 1'b0;
        captured       = 1'b0;
        if (frame_info.frame_end) begin
            if (loud) begin
                quiet_run_next = '0;
                loud_run_next  = loud_inc;
                if (!in_speech_reg &&
                    evad_pkg::RUN_CMP_W'(loud_inc) >= evad_pkg::RUN_CMP_W'(need_loud)) begin
                    in_speech_next = 1'b1;
                    hold_next      = '0;
                    started        = 1'b1;
                end
                captured = in_speech_next;
            end else begin
                loud_run_next = '0;
                if (in_speech_reg) begin
                    quiet_run_next = quiet_inc;
                    if (hold_reg > 0) begin
                        captured   = 1'b1;
                        hold_after = hold_reg - len_s;
                    end
                    if (evad_pkg::RUN_CMP_W'(quiet_inc) >= evad_pkg::RUN_CMP_W'(need_quiet) &&
                        hold_after <= 0) begin
                        in_speech_next = 1'b0;
                        ended          = 1'b1;
                    end
                    // The ramp-down count is loaded on the first quiet frame, after its end test.
                    hold_next = (quiet_inc == evad_pkg::RUN_COUNT_WIDTH'(1)) ? reload_s : hold_after;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_speech_reg <= 1'b0;
            loud_run_reg  <= '0;
            quiet_run_reg <= '0;
            hold_reg      <= '0;
        end else if (advance) begin
            in_speech_reg <= in_speech_next;
            loud_run_reg  <= loud_run_next;
            quiet_run_reg <= quiet_run_next;
            hold_reg      <= hold_next;
        end
    end

    always_comb begin
        result.frame_end      = frame_info.frame_end;
        result.frame_energy   = frame_info.frame_end ? frame_info.energy : '0;
        result.loud_frame     = frame_info.frame_end && loud;
        result.speaking_now   = in_speech_next;
        result.speech_started = started;
        result.speech_ended   = ended;
        result.frame_captured = captured;
    end

endmodule

// ===== rtl/core/energy_voice_activity_detector_top.sv =====
// Energy voice activity detector. Each transaction on the s_ channel carries one signed
// 16-bit sample and yields exactly one transaction on the m_ channel, after it has passed
// the input register and the output register; one sample is taken every cycle while the
// output is not stalled. The sample is squared in the input register stage, and the frame
// sum, the loud test and the speech decision are made between that register and the
// output register. Fields other than speaking_now are only meaningful when frame_end is
// high. Configuration writes must be made while no sample is in flight.
module energy_voice_activity_detector_top (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic [evad_pkg::CFG_INDEX_W-1:0]       cfg_addr,
    input  logic [evad_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [evad_pkg::SAMPLE_W-1:0]   s_sample,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_frame_end,
    output logic [evad_pkg::ENERGY_W-1:0]          m_frame_energy,
    output logic                                   m_loud_frame,
    output logic                                   m_speaking_now,
    output logic                                   m_speech_started,
    output logic                                   m_speech_ended,
    output logic                                   m_frame_captured
);

    logic [evad_pkg::FRAME_LEN_W-1:0]    frame_length_reg;
    logic [evad_pkg::ENERGY_W-1:0]       threshold_reg;
    logic [evad_pkg::MIN_RUN_W-1:0]      min_loud_reg;
    logic [evad_pkg::MIN_RUN_W-1:0]      min_quiet_reg;
    logic [evad_pkg::HOLD_SAMPLES_W-1:0] hold_samples_reg;

    logic                           sq_valid;
    logic [evad_pkg::SQUARE_W-1:0]  square;
    logic                           advance;
    logic                           out_ready;
    logic [evad_pkg::EFF_LEN_W-1:0] frame_len;
    evad_pkg::frame_info_t          frame_info;
    evad_pkg::result_t              result;
    evad_pkg::result_t              result_reg;
    logic                           m_valid_reg;
    logic                           m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_length_reg <= evad_pkg::FRAME_LEN_W'(480);
            threshold_reg    <= evad_pkg::ENERGY_W'(48000000);
            min_loud_reg     <= evad_pkg::MIN_RUN_W'(3);
            min_quiet_reg    <= evad_pkg::MIN_RUN_W'(10);
            hold_samples_reg <= evad_pkg::HOLD_SAMPLES_W'(4800);
        end else if (cfg_we) begin
            case (evad_pkg::cfg_index_t'(cfg_addr))
                evad_pkg::CFG_FRAME_LENGTH: begin
                    frame_length_reg <= cfg_wdata[evad_pkg::FRAME_LEN_W-1:0];
                end
                evad_pkg::CFG_ENERGY_THRESHOLD: begin
                    threshold_reg <= cfg_wdata[evad_pkg::ENERGY_W-1:0];
                end
                evad_pkg::CFG_MIN_LOUD_FRAMES: begin
                    min_loud_reg <= cfg_wdata[evad_pkg::MIN_RUN_W-1:0];
                end
                evad_pkg::CFG_MIN_QUIET_FRAMES: begin
                    min_quiet_reg <= cfg_wdata[evad_pkg::MIN_RUN_W-1:0];
                end
                evad_pkg::CFG_HOLD_SAMPLES: begin
                    hold_samples_reg <= cfg_wdata[evad_pkg::HOLD_SAMPLES_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign frame_len = evad_pkg::eff_length(frame_length_reg);
    assign out_ready = !m_valid_reg || m_ready;
    assign advance   = sq_valid && out_ready;

    evad_input_stage u_input_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_sample (s_sample),
        .advance  (advance),
        .sq_valid (sq_valid),
        .square   (square)
    );

    evad_frame_acc u_frame_acc (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .square     (square),
        .frame_len  (frame_len),
        .frame_info (frame_info)
    );

    evad_speech_ctrl u_speech_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (advance),
        .frame_info   (frame_info),
        .frame_len    (frame_len),
        .threshold    (threshold_reg),
        .min_loud     (min_loud_reg),
        .min_quiet    (min_quiet_reg),
        .hold_samples (hold_samples_reg),
        .result       (result)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_frame_end      = result_reg.frame_end;
    assign m_frame_energy   = result_reg.frame_energy;
    assign m_loud_frame     = result_reg.loud_frame;
    assign m_speaking_now   = result_reg.speaking_now;
    assign m_speech_started = result_reg.speech_started;
    assign m_speech_ended   = result_reg.speech_ended;
    assign m_frame_captured = result_reg.frame_captured;

    // Events are only reported on a frame end, and never both in the same transaction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_speech_started || m_speech_ended || m_frame_captured || m_loud_frame)
        |-> m_frame_end)
    else $error("speech event reported outside a frame end");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_speech_started |-> m_speaking_now && !m_speech_ended && m_loud_frame)
    else $error("speech start inconsistent with speech state");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_speech_ended |-> !m_speaking_now && !m_loud_frame)
    else $error("speech end inconsistent with speech state");

    // A result held under back-pressure must not be overwritten by the pipeline.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(result_reg))
    else $error("stalled result changed");

endmodule
